@@ hdl/assert_macros.svh @@
// Assertion macros used by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/cfr_pkg.sv @@
// Types and constants of the command frame receiver.
`default_nettype none

package cfr_pkg;

    localparam int unsigned CRC_W = 16;

    // Result event codes
    typedef enum logic [3:0] {
        EV_BUZZ_ON    = 4'd0,
        EV_LIGHT_ON   = 4'd1,
        EV_BUZZ_OFF   = 4'd2,
        EV_LIGHT_OFF  = 4'd3,
        EV_KEY_QUERY  = 4'd4,
        EV_VER_QUERY  = 4'd5,
        EV_READ_CAL   = 4'd6,
        EV_CAL_OK     = 4'd7,
        EV_BAUD_SET   = 4'd8,
        EV_BAUD_ZERO  = 4'd9,
        EV_CRC_ERR    = 4'd10,
        EV_TIMEOUT    = 4'd11
    } event_t;

    // Receiver mode; the unused code behaves as idle
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CAL  = 2'd1,
        MODE_BAUD = 2'd2
    } mode_t;

    // Item kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic CFG_CRC_POLY = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    localparam logic [CRC_W-1:0] CRC_POLY_RESET = 16'h1021;
    localparam logic [15:0]      TIMEOUT_RESET  = 16'd3000;

    // Received byte codes
    localparam logic [7:0] BYTE_PREFIX     = 8'hFE;
    localparam logic [7:0] BYTE_CAL_FRAME  = 8'h01;
    localparam logic [7:0] BYTE_READ_CAL   = 8'h03;
    localparam logic [7:0] BYTE_BAUD_FRAME = 8'h51;
    localparam logic [7:0] BYTE_BUZZ_ON    = 8'hA0;
    localparam logic [7:0] BYTE_LIGHT_ON   = 8'h0A;
    localparam logic [7:0] BYTE_BUZZ_OFF   = 8'h50;
    localparam logic [7:0] BYTE_LIGHT_OFF  = 8'h05;
    localparam logic [7:0] BYTE_KEY_QUERY  = 8'h29;
    localparam logic [7:0] BYTE_VER_QUERY  = 8'h77;

endpackage

`default_nettype wire

@@ hdl/command_frame_receiver_crc16.sv @@
// Top level of the serial command frame receiver with CRC-16 check.
//
//  channel   dir  handshake               payload
//  s_        in   s_valid / s_ready       s_cmd, s_data_byte
//  m_        out  m_valid / m_ready       m_event_res, m_baud_value, m_frame_length
//  cfg_      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per cycle unless the result side stalls: an item waits in the input register,
// then the parser state and the result register update in the same cycle; the byte-wide
// CRC step is the longest path. m_valid rises once a result has passed both registers.
// Synchronous active-low reset clears all control state and loads the register
// defaults. A stalled result holds the input register; the input side keeps
// taking items while either register has room. cfg_ready is always high.
`default_nettype none

module command_frame_receiver_crc16
    import cfr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 96
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [7:0]  s_data_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_event_res,
    output logic [31:0]      m_baud_value,
    output logic [15:0]      m_frame_length,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    `include "assert_macros.svh"

    // Configuration registers
    logic [CRC_W-1:0] crc_poly_reg;
    logic [15:0]      timeout_ticks_reg;

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;

    // Parser state
    logic             prefix_seen_reg, prefix_seen_next;
    mode_t            mode_reg, mode_next;
    logic [7:0]       byte_count_reg, byte_count_next;
    logic [15:0]      declared_length_reg, declared_length_next;
    logic [CRC_W-1:0] running_crc_reg, running_crc_next;
    logic [7:0]       crc_high_reg, crc_high_next;
    logic [31:0]      baud_accum_reg, baud_accum_next;
    logic [15:0]      tick_count_reg, tick_count_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    event_t      out_event_reg;
    logic [31:0] out_baud_reg;
    logic [15:0] out_len_reg;

    // Decode
    logic             s_accept, advance;
    logic             is_tick, busy;
    logic [15:0]      tick_inc;
    logic             timeout_hit;
    logic             len_ok;
    logic [8:0]       idx9, len9;
    logic             crc_phase, crc_hi_phase, crc_lo_phase;
    logic             crc_match;
    logic [31:0]      baud_or;
    logic [CRC_W-1:0] crc_step;

    // Result
    logic        res_valid;
    event_t      res_event;
    logic [31:0] res_baud;
    logic [15:0] res_len;

    // Check terms
    logic chk_baud_set, chk_good_close, chk_closed, chk_timeout, chk_timer_clear;

    // Handshakes
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid        = out_valid_reg;
    assign m_event_res    = out_event_reg;
    assign m_baud_value   = out_baud_reg;
    assign m_frame_length = out_len_reg;

    cfr_crc_byte u_crc (
        .crc_in    (running_crc_reg),
        .data_byte (in_byte_reg),
        .poly      (crc_poly_reg),
        .crc_out   (crc_step)
    );

    // Shared decode of the item in the input register
    always_comb begin
        is_tick     = (in_cmd_reg == CMD_TICK);
        busy        = (mode_reg == MODE_CAL) || (mode_reg == MODE_BAUD);
        tick_inc    = (tick_count_reg != 16'hFFFF) ? tick_count_reg + 16'd1 : tick_count_reg;
        timeout_hit = busy && (tick_inc >= timeout_ticks_reg);
        len_ok      = (declared_length_reg <= 16'(MAX_PAYLOAD));
        idx9        = {1'b0, byte_count_reg};
        len9        = {1'b0, declared_length_reg[7:0]};
        crc_phase    = idx9 < (len9 + 9'd2);
        crc_hi_phase = idx9 == (len9 + 9'd2);
        crc_lo_phase = idx9 == (len9 + 9'd3);
        crc_match    = (running_crc_reg == {crc_high_reg, in_byte_reg});
        // Place the first four payload bytes big-endian
        case (byte_count_reg)
            8'd2:    baud_or = baud_accum_reg | {in_byte_reg, 24'h000000};
            8'd3:    baud_or = baud_accum_reg | {8'h00, in_byte_reg, 16'h0000};
            8'd4:    baud_or = baud_accum_reg | {16'h0000, in_byte_reg, 8'h00};
            8'd5:    baud_or = baud_accum_reg | {24'h000000, in_byte_reg};
            default: baud_or = baud_accum_reg;
        endcase
    end

    // Next parser state
    always_comb begin
        prefix_seen_next     = prefix_seen_reg;
        mode_next            = mode_reg;
        byte_count_next      = byte_count_reg;
        declared_length_next = declared_length_reg;
        running_crc_next     = running_crc_reg;
        crc_high_next        = crc_high_reg;
        baud_accum_next      = baud_accum_reg;
        tick_count_next      = tick_count_reg;
        if (advance) begin
            if (is_tick) begin
                tick_count_next = tick_inc;
                // Drop the open frame
                if (timeout_hit) begin
                    prefix_seen_next     = 1'b0;
                    mode_next            = MODE_IDLE;
                    declared_length_next = '0;
                    tick_count_next      = '0;
                    byte_count_next      = '0;
                    running_crc_next     = '0;
                    crc_high_next        = '0;
                    baud_accum_next      = '0;
                end
            end else if (!busy) begin
                if (in_byte_reg == BYTE_PREFIX && !prefix_seen_reg) begin
                    prefix_seen_next = 1'b1;
                end else if (prefix_seen_reg && (in_byte_reg == BYTE_CAL_FRAME ||
                                                 in_byte_reg == BYTE_BAUD_FRAME)) begin
                    mode_next       = (in_byte_reg == BYTE_CAL_FRAME) ? MODE_CAL : MODE_BAUD;
                    tick_count_next = '0;
                end else if (prefix_seen_reg && in_byte_reg == BYTE_READ_CAL) begin
                    prefix_seen_next = 1'b0;
                end
            end else begin
                byte_count_next = (byte_count_reg != 8'hFF) ? byte_count_reg + 8'd1
                                                             : byte_count_reg;
                if (byte_count_reg == 8'd0) begin
                    declared_length_next = declared_length_reg | {in_byte_reg, 8'h00};
                end else if (byte_count_reg == 8'd1) begin
                    declared_length_next = declared_length_reg | {8'h00, in_byte_reg};
                end else begin
                    baud_accum_next = baud_or;
                    if (len_ok) begin
                        if (crc_phase) begin
                            running_crc_next = crc_step;
                        end else if (crc_hi_phase) begin
                            crc_high_next = in_byte_reg;
                        end else if (crc_lo_phase) begin
                            byte_count_next  = '0;
                            running_crc_next = '0;
                            crc_high_next    = '0;
                            baud_accum_next  = '0;
                            // Close the frame only on a good check
                            if (crc_match) begin
                                prefix_seen_next     = 1'b0;
                                mode_next            = MODE_IDLE;
                                declared_length_next = '0;
                            end
                        end
                    end
                end
            end
        end
    end

    // Result of the current item
    always_comb begin
        res_valid = 1'b0;
        res_event = EV_BUZZ_ON;
        res_baud  = '0;
        res_len   = '0;
        if (is_tick) begin
            if (timeout_hit) begin
                res_valid = 1'b1;
                res_event = EV_TIMEOUT;
            end
        end else if (!busy) begin
            if (in_byte_reg == BYTE_PREFIX && !prefix_seen_reg) begin
                res_valid = 1'b0;
            end else if (prefix_seen_reg && (in_byte_reg == BYTE_CAL_FRAME ||
                                             in_byte_reg == BYTE_BAUD_FRAME)) begin
                res_valid = 1'b0;
            end else if (prefix_seen_reg && in_byte_reg == BYTE_READ_CAL) begin
                res_valid = 1'b1;
                res_event = EV_READ_CAL;
            end else begin
                res_valid = 1'b1;
                case (in_byte_reg)
                    BYTE_BUZZ_ON:   res_event = EV_BUZZ_ON;
                    BYTE_LIGHT_ON:  res_event = EV_LIGHT_ON;
                    BYTE_BUZZ_OFF:  res_event = EV_BUZZ_OFF;
                    BYTE_LIGHT_OFF: res_event = EV_LIGHT_OFF;
                    BYTE_KEY_QUERY: res_event = EV_KEY_QUERY;
                    BYTE_VER_QUERY: res_event = EV_VER_QUERY;
                    default:        res_valid = 1'b0;
                endcase
            end
        end else if (byte_count_reg >= 8'd2 && len_ok && crc_lo_phase) begin
            res_valid = 1'b1;
            res_len   = declared_length_reg;
            if (!crc_match) begin
                res_event = EV_CRC_ERR;
            end else if (mode_reg == MODE_CAL) begin
                res_event = EV_CAL_OK;
            end else if (baud_or != 32'd0) begin
                res_event = EV_BAUD_SET;
                res_baud  = baud_or;
            end else begin
                res_event = EV_BAUD_ZERO;
            end
        end
    end

    // Input and result register valids
    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_poly_reg        <= CRC_POLY_RESET;
            timeout_ticks_reg   <= TIMEOUT_RESET;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            prefix_seen_reg     <= 1'b0;
            mode_reg            <= MODE_IDLE;
            byte_count_reg      <= '0;
            declared_length_reg <= '0;
            running_crc_reg     <= '0;
            crc_high_reg        <= '0;
            baud_accum_reg      <= '0;
            tick_count_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CRC_POLY: crc_poly_reg      <= cfg_data;
                    CFG_TIMEOUT:  timeout_ticks_reg <= cfg_data;
                    default:      crc_poly_reg      <= crc_poly_reg;
                endcase
            end
            in_valid_reg        <= in_valid_next;
            out_valid_reg       <= out_valid_next;
            prefix_seen_reg     <= prefix_seen_next;
            mode_reg            <= mode_next;
            byte_count_reg      <= byte_count_next;
            declared_length_reg <= declared_length_next;
            running_crc_reg     <= running_crc_next;
            crc_high_reg        <= crc_high_next;
            baud_accum_reg      <= baud_accum_next;
            tick_count_reg      <= tick_count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg  <= s_cmd;
            in_byte_reg <= s_data_byte;
        end
        if (advance) begin
            out_event_reg <= res_event;
            out_baud_reg  <= res_baud;
            out_len_reg   <= res_len;
        end
    end

    // Checks
    assign chk_baud_set    = out_valid_reg && (out_event_reg == EV_BAUD_SET);
    assign chk_good_close  = advance && res_valid &&
                             (res_event == EV_CAL_OK || res_event == EV_BAUD_SET ||
                              res_event == EV_BAUD_ZERO);
    assign chk_closed      = (mode_reg == MODE_IDLE) && !prefix_seen_reg &&
                             (byte_count_reg == 8'd0);
    assign chk_timeout     = advance && res_valid && (res_event == EV_TIMEOUT);
    assign chk_timer_clear = (tick_count_reg == 16'd0) && (mode_reg == MODE_IDLE);

    `ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)
    `ASSERT_IMPLIES(a_baud_set_nonzero, aclk, aresetn, chk_baud_set, out_baud_reg != 32'd0)
    `ASSERT_NEXT(a_good_frame_closes, aclk, aresetn, chk_good_close, chk_closed)
    `ASSERT_NEXT(a_timeout_clears, aclk, aresetn, chk_timeout, chk_timer_clear)

endmodule

`default_nettype wire

@@ hdl/cfr_crc_byte.sv @@
// One-byte CRC update, MSB first, with a programmable polynomial.
`default_nettype none

module cfr_crc_byte
    import cfr_pkg::*;
(
    input  wire logic [CRC_W-1:0] crc_in,
    input  wire logic [7:0]       data_byte,
    input  wire logic [CRC_W-1:0] poly,
    output logic      [CRC_W-1:0] crc_out
);

    // Fold the byte into the top and shift out eight bits
    always_comb begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data_byte, {(CRC_W-8){1'b0}}};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the command frame receiver: byte and tick stimulus, predicted events.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cfr_pkg::*;

    localparam int FRAME_MAX     = 96;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        event_t      ev;
        logic [31:0] baud;
        logic [15:0] len;
    } outcome_t;

    // Receiver behavior mirror plus the queue of events still owed by the block
    class frame_scoreboard;
        logic [15:0] poly = CRC_POLY_RESET;
        logic [15:0] tmo  = TIMEOUT_RESET;
        logic        armed = 1'b0;
        mode_t       mode = MODE_IDLE;
        logic [7:0]  count = '0;
        logic [15:0] decl = '0;
        logic [15:0] crc = '0;
        logic [7:0]  crc_hi = '0;
        logic [31:0] baud = '0;
        logic [15:0] ticks = '0;
        outcome_t    expected_q[$];
        int          n_err;
        int          n_items;
        int          n_checked;
        int          ev_hist[12];

        function void set_reg(logic idx, logic [15:0] value);
            if (idx == CFG_CRC_POLY) begin
                poly = value;
            end else begin
                tmo = value;
            end
        endfunction

        // One byte through the CRC register, MSB first
        function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
            logic [15:0] c;
            c = acc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) begin
                c = c[15] ? ((c << 1) ^ poly) : (c << 1);
            end
            return c;
        endfunction

        function void clear_frame();
            count  = '0;
            crc    = '0;
            crc_hi = '0;
            baud   = '0;
        endfunction

        function void expect_event(event_t ev, logic [31:0] bv, logic [15:0] fl);
            expected_q.push_back('{ev, bv, fl});
        endfunction

        // Advance the mirror by one accepted item
        function void note_item(logic cmd, logic [7:0] b);
            bit          busy;
            int          idx;
            bit          ok;
            logic [31:0] baud_done;
            mode_t       mode_done;
            logic [15:0] len_done;
            n_items++;
            busy = (mode == MODE_CAL) || (mode == MODE_BAUD);

            // Tick: bump the busy timer, abandon an open frame on expiry
            if (cmd == CMD_TICK) begin
                if (ticks != 16'hFFFF) ticks++;
                if (busy && ticks >= tmo) begin
                    armed = 1'b0;
                    mode  = MODE_IDLE;
                    decl  = '0;
                    ticks = '0;
                    clear_frame();
                    expect_event(EV_TIMEOUT, '0, '0);
                end
                return;
            end

            // Idle: prefix handling and single command bytes
            if (!busy) begin
                if (b == BYTE_PREFIX && !armed) begin
                    armed = 1'b1;
                    return;
                end
                if (armed) begin
                    if (b == BYTE_CAL_FRAME || b == BYTE_BAUD_FRAME) begin
                        mode  = (b == BYTE_CAL_FRAME) ? MODE_CAL : MODE_BAUD;
                        ticks = '0;
                        return;
                    end
                    if (b == BYTE_READ_CAL) begin
                        armed = 1'b0;
                        expect_event(EV_READ_CAL, '0, '0);
                        return;
                    end
                end
                case (b)
                    BYTE_BUZZ_ON:   expect_event(EV_BUZZ_ON, '0, '0);
                    BYTE_LIGHT_ON:  expect_event(EV_LIGHT_ON, '0, '0);
                    BYTE_BUZZ_OFF:  expect_event(EV_BUZZ_OFF, '0, '0);
                    BYTE_LIGHT_OFF: expect_event(EV_LIGHT_OFF, '0, '0);
                    BYTE_KEY_QUERY: expect_event(EV_KEY_QUERY, '0, '0);
                    BYTE_VER_QUERY: expect_event(EV_VER_QUERY, '0, '0);
                    default: ;
                endcase
                return;
            end

            // Frame body: length, payload, CRC high and low
            idx = count;
            if (count != 8'hFF) count++;
            if (idx == 0) begin
                decl |= {b, 8'h00};
                return;
            end
            if (idx == 1) begin
                decl |= {8'h00, b};
                return;
            end
            if (idx <= 5) baud |= 32'(b) << (8 * (5 - idx));
            if (int'(decl) > FRAME_MAX) return;
            if (idx < int'(decl) + 2) begin
                crc = crc_step(crc, b);
                return;
            end
            if (idx == int'(decl) + 2) begin
                crc_hi = b;
                return;
            end
            if (idx == int'(decl) + 3) begin
                ok        = (crc == {crc_hi, b});
                baud_done = baud;
                mode_done = mode;
                len_done  = decl;
                clear_frame();
                // Mismatch keeps the frame open, the prefix armed and the length
                if (!ok) begin
                    expect_event(EV_CRC_ERR, '0, len_done);
                    return;
                end
                armed = 1'b0;
                mode  = MODE_IDLE;
                decl  = '0;
                if (mode_done == MODE_CAL) begin
                    expect_event(EV_CAL_OK, '0, len_done);
                end else if (baud_done != '0) begin
                    expect_event(EV_BAUD_SET, baud_done, len_done);
                end else begin
                    expect_event(EV_BAUD_ZERO, '0, len_done);
                end
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [3:0] ev, logic [31:0] bv, logic [15:0] fl);
            outcome_t want;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: event_res %0d", ev);
                n_err++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            ev_hist[int'(want.ev)]++;
            if (ev !== want.ev) begin
                $error("event_res: expected %0d, actual %0d", want.ev, ev);
                n_err++;
            end
            if (bv !== want.baud) begin
                $error("baud_value: expected %0h, actual %0h", want.baud, bv);
                n_err++;
            end
            if (fl !== want.len) begin
                $error("frame_length: expected %0d, actual %0d", want.len, fl);
                n_err++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_cmd;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_event_res;
    logic [31:0] m_baud_value;
    logic [15:0] m_frame_length;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    frame_scoreboard sb = new;
    item_t           stim_q[$];
    int              tx_gap_max = 8;
    int              rx_gap_max = 8;
    bit              hold_rx = 1'b0;
    int              cycle_cnt = 0;
    logic [7:0]      cmd_bytes[6] = '{BYTE_BUZZ_ON, BYTE_LIGHT_ON, BYTE_BUZZ_OFF,
                                      BYTE_LIGHT_OFF, BYTE_KEY_QUERY, BYTE_VER_QUERY};

    command_frame_receiver_crc16 #(
        .MAX_PAYLOAD(FRAME_MAX)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_baud_value  (m_baud_value),
        .m_frame_length(m_frame_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Stimulus builders
    function void add_byte(logic [7:0] b);
        stim_q.push_back('{CMD_BYTE, b});
    endfunction

    function void add_ticks(int n);
        repeat (n) stim_q.push_back('{CMD_TICK, 8'($urandom)});
    endfunction

    // Frame with a correct or corrupted CRC; reopen skips the prefix and opener
    function void add_frame(logic [7:0] opener, int len, bit bad_crc, bit zero_body,
                            bit reopen);
        logic [15:0] acc;
        logic [7:0]  b;
        acc = '0;
        if (!reopen) begin
            add_byte(BYTE_PREFIX);
            add_byte(opener);
        end
        add_byte(8'(len >> 8));
        add_byte(8'(len));
        for (int i = 0; i < len; i++) begin
            b = zero_body ? 8'h00 : 8'($urandom);
            acc = sb.crc_step(acc, b);
            add_byte(b);
        end
        if (bad_crc) acc ^= 16'(1) << $urandom_range(0, 15);
        add_byte(acc[15:8]);
        add_byte(acc[7:0]);
    endfunction

    // Mostly well-formed frames and commands, the rest broken frames and noise
    function void build_random(int n, bit broken);
        int         r;
        int         len;
        logic [7:0] opener;
        logic [7:0] b;
        while (stim_q.size() < n) begin
            r = $urandom_range(0, 99);
            opener = $urandom_range(0, 1) ? BYTE_CAL_FRAME : BYTE_BAUD_FRAME;
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, FRAME_MAX)
                                               : $urandom_range(0, 12);
            if (r < 40) begin
                add_frame(opener, len, 1'b0,
                          opener == BYTE_BAUD_FRAME && $urandom_range(0, 5) == 0, 1'b0);
            end else if (r < 50 && broken) begin
                add_frame(opener, len, 1'b1, 1'b0, 1'b0);
                // Retry with the same length, or let the timer clear it
                if ($urandom_range(0, 1)) begin
                    add_frame(opener, len, 1'b0, 1'b0, 1'b1);
                end else begin
                    add_ticks(sb.tmo);
                end
            end else if (r < 55 && broken) begin
                add_byte(BYTE_PREFIX);
                add_byte(opener);
                len = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                  : $urandom_range(FRAME_MAX + 1, 16'hFFFF);
                add_byte(8'(len >> 8));
                add_byte(8'(len));
                repeat ($urandom_range(0, 8)) add_byte(8'($urandom));
                add_ticks(sb.tmo);
            end else if (r < 65) begin
                add_byte(cmd_bytes[$urandom_range(0, 5)]);
            end else if (r < 72) begin
                add_byte(BYTE_PREFIX);
                add_byte(BYTE_READ_CAL);
            end else if (r < 90) begin
                b = 8'($urandom);
                if (broken || b != BYTE_PREFIX) add_byte(b);
            end else begin
                add_ticks($urandom_range(1, 3));
            end
        end
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task send_item(item_t it);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_cmd       <= it.cmd;
        s_data_byte <= it.data;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it.cmd, it.data);
    endtask

    task drive_stimulus();
        while (stim_q.size() > 0) send_item(stim_q.pop_front());
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Wait for every owed event, then for the block's own latency
    task settle();
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task reg_write(logic idx, logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, value);
    endtask

    task write_regs(logic [15:0] poly, logic [15:0] tmo);
        reg_write(CFG_CRC_POLY, poly);
        reg_write(CFG_TIMEOUT, tmo);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task run_phase(logic [15:0] poly, logic [15:0] tmo, int n, bit broken);
        settle();
        write_regs(poly, tmo);
        build_random(n, broken);
        drive_stimulus();
    endtask

    // Result side: random stall after each item, plus the long hold-off
    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_event_res, m_baud_value, m_frame_length);
                stall = $urandom_range(0, rx_gap_max);
            end
            @(negedge aclk);
            if (hold_rx || stall > 0) begin
                m_ready <= 1'b0;
                if (stall > 0) stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_cmd       = CMD_BYTE;
        s_data_byte = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_CRC_POLY;
        cfg_data    = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every command, unknown bytes, prefix quirks, short frames, timeout
        write_regs(CRC_POLY_RESET, 16'd1);
        foreach (cmd_bytes[i]) add_byte(cmd_bytes[i]);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(BYTE_PREFIX);
        add_byte(BYTE_PREFIX);
        add_byte(BYTE_BUZZ_ON);
        add_byte(BYTE_READ_CAL);
        add_frame(BYTE_BAUD_FRAME, 0, 1'b0, 1'b0, 1'b0);
        add_frame(BYTE_BAUD_FRAME, 0, 1'b1, 1'b0, 1'b0);
        add_ticks(1);
        drive_stimulus();

        // Random phases across register settings
        run_phase(16'h1021, 16'd40, 400, 1'b1);
        run_phase(16'hFFFF, 16'd1, 200, 1'b1);
        run_phase(16'h0000, 16'hFFFF, 200, 1'b0);
        settle();
        tx_gap_max = 0;
        rx_gap_max = 0;
        run_phase(16'($urandom), 16'($urandom_range(20, 60)), 250, 1'b1);
        settle();
        tx_gap_max = 8;
        rx_gap_max = 8;

        // Back-pressure: hold the result side while commands stream in
        write_regs(16'h8005, 16'd30);
        repeat (120) add_byte(cmd_bytes[$urandom_range(0, 5)]);
        tx_gap_max = 0;
        fork
            begin
                hold_rx = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end
            drive_stimulus();
        join
        settle();

        $display("tb_top: %0d items over six register settings, %0d results compared",
                 sb.n_items, sb.n_checked);
        $display("tb_top: %0d frames accepted, %0d CRC rejects, %0d timeouts",
                 sb.ev_hist[EV_CAL_OK] + sb.ev_hist[EV_BAUD_SET] + sb.ev_hist[EV_BAUD_ZERO],
                 sb.ev_hist[EV_CRC_ERR], sb.ev_hist[EV_TIMEOUT]);
        if (sb.n_err == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/cfr_pkg.sv
hdl/cfr_crc_byte.sv
hdl/command_frame_receiver_crc16.sv
bench/tb_top.sv
